// ===== design/iebm_pkg.sv =====
// Package for the I2C EEPROM / clock chip byte master.
// Beat payload types, configuration struct, bus phase and stage codes.
// Depends on nothing.
`default_nettype none

package iebm_pkg;

  localparam int AddrW    = 17;
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_EEPROM_LOW  = 2'd1;
  localparam logic [1:0] REG_EEPROM_HIGH = 2'd2;
  localparam logic [1:0] REG_CLOCK_CHIP  = 2'd3;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd4;
  localparam logic [7:0] EEPROM_LOW_RST  = 8'hA0;
  localparam logic [7:0] EEPROM_HIGH_RST = 8'hA2;
  localparam logic [7:0] CLOCK_CHIP_RST  = 8'hD0;

  // Command actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic TARGET_EEPROM = 1'b0;
  localparam logic TARGET_CLOCK  = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic             target;
    logic [AddrW-1:0] mem_address;
    logic [7:0]       write_data;
    logic             sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       cmd_rejected;
  } res_t;

  typedef struct packed {
    logic [7:0] half_period_ticks;
    logic [7:0] eeprom_low_id;
    logic [7:0] eeprom_high_id;
    logic [7:0] clock_chip_id;
  } cfg_t;

  typedef enum logic [15:0] {
    PH_IDLE    = 16'h0001,
    PH_ST_LO   = 16'h0002,
    PH_ST_HI   = 16'h0004,
    PH_ST_FALL = 16'h0008,
    PH_ST_LOW  = 16'h0010,
    PH_TX_LO   = 16'h0020,
    PH_TX_HI   = 16'h0040,
    PH_ACK_LO  = 16'h0080,
    PH_ACK_HI  = 16'h0100,
    PH_RX_LO   = 16'h0200,
    PH_RX_HI   = 16'h0400,
    PH_NAK_LO  = 16'h0800,
    PH_NAK_HI  = 16'h1000,
    PH_SP_LO   = 16'h2000,
    PH_SP_HI   = 16'h4000,
    PH_SP_REL  = 16'h8000
  } phase_t;

  typedef enum logic [8:0] {
    SG_CTRL  = 9'h001,
    SG_AH    = 9'h002,
    SG_AL    = 9'h004,
    SG_DATA  = 9'h008,
    SG_RCTRL = 9'h010,
    SG_RX    = 9'h020,
    SG_WSTOP = 9'h040,
    SG_POLL  = 9'h080,
    SG_END   = 9'h100
  } stage_t;

endpackage

`default_nettype wire

// ===== design/iebm_cfg_regs.sv =====
// APB-style configuration registers of the byte master.
// Depends on iebm_pkg.
`default_nettype none

module iebm_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [iebm_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [iebm_pkg::ApbDataW-1:0] pwdata,
  output logic      [iebm_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  output iebm_pkg::cfg_t                     cfg
);
  import iebm_pkg::*;

  logic       wr_en;
  logic [1:0] reg_index;
  logic [7:0] rd_byte;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_PERIOD_RST;
      cfg.eeprom_low_id     <= EEPROM_LOW_RST;
      cfg.eeprom_high_id    <= EEPROM_HIGH_RST;
      cfg.clock_chip_id     <= CLOCK_CHIP_RST;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_HALF_PERIOD: cfg.half_period_ticks <= pwdata[7:0];
        REG_EEPROM_LOW:  cfg.eeprom_low_id     <= pwdata[7:0];
        REG_EEPROM_HIGH: cfg.eeprom_high_id    <= pwdata[7:0];
        REG_CLOCK_CHIP:  cfg.clock_chip_id     <= pwdata[7:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_HALF_PERIOD: rd_byte = cfg.half_period_ticks;
      REG_EEPROM_LOW:  rd_byte = cfg.eeprom_low_id;
      REG_EEPROM_HIGH: rd_byte = cfg.eeprom_high_id;
      REG_CLOCK_CHIP:  rd_byte = cfg.clock_chip_id;
      default:         rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(ApbDataW-8){1'b0}}, rd_byte};

endmodule

`default_nettype wire

// ===== design/iebm_bus_engine.sv =====
// Bus state machine: holds transaction state, computes one result per tick.
// Depends on iebm_pkg.
`default_nettype none

module iebm_bus_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  iebm_pkg::cfg_t      cfg,
  input  wire logic           step,
  input  iebm_pkg::cmd_t      item,
  output iebm_pkg::res_t      result
);
  import iebm_pkg::*;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  tick_count, tick_count_next;
  logic [15:0] held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic        held_is_read, held_is_read_next;
  logic        held_target, held_target_next;
  logic [7:0]  held_control, held_control_next;
  logic [7:0]  received_byte, received_byte_next;

  logic        is_cmd;
  logic [7:0]  half;
  logic [7:0]  ctrl_sel;
  logic [3:0]  bit_inc;
  logic [7:0]  rx_shift;
  logic        step_end;
  logic        hold_high;
  logic        done;
  logic        scl, rel;

  assign is_cmd   = (item.action == ACT_WRITE) || (item.action == ACT_READ);
  assign half     = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
  assign bit_inc  = bit_index + 4'd1;
  assign rx_shift = {shift_byte[6:0], item.sda_in};
  assign step_end = ({1'b0, tick_count} + 9'd1) >= {1'b0, half};
  assign ctrl_sel = (item.target == TARGET_CLOCK) ? cfg.clock_chip_id :
                    (item.mem_address[16] ? cfg.eeprom_high_id : cfg.eeprom_low_id);

  // Line levels come from the phase held before this tick
  always_comb begin
    unique case (phase)
      PH_ST_LO:   begin scl = 1'b0; rel = 1'b1; end
      PH_ST_HI:   begin scl = 1'b1; rel = 1'b1; end
      PH_ST_FALL: begin scl = 1'b1; rel = 1'b0; end
      PH_ST_LOW:  begin scl = 1'b0; rel = 1'b0; end
      PH_TX_LO:   begin scl = 1'b0; rel = shift_byte[7]; end
      PH_TX_HI:   begin scl = 1'b1; rel = shift_byte[7]; end
      PH_ACK_LO, PH_RX_LO, PH_NAK_LO: begin scl = 1'b0; rel = 1'b1; end
      PH_ACK_HI, PH_RX_HI, PH_NAK_HI: begin scl = 1'b1; rel = 1'b1; end
      PH_SP_LO:   begin scl = 1'b0; rel = 1'b0; end
      PH_SP_HI:   begin scl = 1'b1; rel = 1'b0; end
      default:    begin scl = 1'b1; rel = 1'b1; end
    endcase
  end

  always_comb begin
    phase_next         = phase;
    stage_next         = stage;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    tick_count_next    = tick_count;
    held_address_next  = held_address;
    held_data_next     = held_data;
    held_is_read_next  = held_is_read;
    held_target_next   = held_target;
    held_control_next  = held_control;
    received_byte_next = received_byte;
    hold_high          = 1'b0;
    done               = 1'b0;
    result.cmd_rejected = 1'b0;

    if (phase == PH_IDLE && is_cmd) begin
      held_target_next  = item.target;
      held_address_next = item.mem_address[15:0];
      held_data_next    = item.write_data;
      held_is_read_next = (item.action == ACT_READ);
      held_control_next = ctrl_sel;
      tick_count_next   = 8'd0;
      shift_byte_next   = ctrl_sel;
      bit_index_next    = 4'd0;
      stage_next        = SG_CTRL;
      phase_next        = PH_ST_LO;
    end else begin
      result.cmd_rejected = is_cmd;
      if (phase != PH_IDLE) begin
        if (step_end) begin
          unique case (phase)
            PH_ST_LO:   phase_next = PH_ST_HI;
            PH_ST_HI:   phase_next = PH_ST_FALL;
            PH_ST_FALL: phase_next = PH_ST_LOW;
            PH_ST_LOW: begin
              phase_next     = PH_TX_LO;
              bit_index_next = 4'd0;
            end
            PH_TX_LO:   phase_next = PH_TX_HI;
            PH_TX_HI: begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_index_next  = bit_inc;
              phase_next      = bit_inc[3] ? PH_ACK_LO : PH_TX_LO;
            end
            PH_ACK_LO:  phase_next = PH_ACK_HI;
            PH_ACK_HI: begin
              if (item.sda_in) begin
                // no acknowledge: polling restarts, otherwise keep SCL high
                if (stage == SG_POLL) begin
                  shift_byte_next = held_control;
                  bit_index_next  = 4'd0;
                  phase_next      = PH_ST_LO;
                end else begin
                  hold_high = 1'b1;
                end
              end else begin
                unique case (stage)
                  SG_CTRL: begin
                    shift_byte_next = held_target ? held_address[7:0] : held_address[15:8];
                    bit_index_next  = 4'd0;
                    stage_next      = held_target ? SG_AL : SG_AH;
                    phase_next      = PH_TX_LO;
                  end
                  SG_AH: begin
                    shift_byte_next = held_address[7:0];
                    bit_index_next  = 4'd0;
                    stage_next      = SG_AL;
                    phase_next      = PH_TX_LO;
                  end
                  SG_AL: begin
                    bit_index_next = 4'd0;
                    if (held_is_read) begin
                      shift_byte_next = held_control | 8'h01;
                      stage_next      = SG_RCTRL;
                      phase_next      = PH_ST_LO;
                    end else begin
                      shift_byte_next = held_data;
                      stage_next      = SG_DATA;
                      phase_next      = PH_TX_LO;
                    end
                  end
                  SG_DATA: begin
                    stage_next = SG_WSTOP;
                    phase_next = PH_SP_LO;
                  end
                  SG_RCTRL: begin
                    stage_next      = SG_RX;
                    phase_next      = PH_RX_LO;
                    bit_index_next  = 4'd0;
                    shift_byte_next = 8'd0;
                  end
                  default: begin
                    stage_next = SG_END;
                    phase_next = PH_SP_LO;
                  end
                endcase
              end
            end
            PH_RX_LO:   phase_next = PH_RX_HI;
            PH_RX_HI: begin
              shift_byte_next = rx_shift;
              bit_index_next  = bit_inc;
              if (bit_inc[3]) begin
                received_byte_next = rx_shift;
                phase_next         = PH_NAK_LO;
              end else begin
                phase_next = PH_RX_LO;
              end
            end
            PH_NAK_LO:  phase_next = PH_NAK_HI;
            PH_NAK_HI: begin
              stage_next = SG_END;
              phase_next = PH_SP_LO;
            end
            PH_SP_LO:   phase_next = PH_SP_HI;
            PH_SP_HI:   phase_next = PH_SP_REL;
            PH_SP_REL: begin
              if (stage == SG_WSTOP) begin
                shift_byte_next = held_control;
                bit_index_next  = 4'd0;
                stage_next      = SG_POLL;
                phase_next      = PH_ST_LO;
              end else begin
                phase_next = PH_IDLE;
                stage_next = SG_CTRL;
                done       = 1'b1;
              end
            end
            default:    phase_next = PH_IDLE;
          endcase
          tick_count_next = hold_high ? (half - 8'd1) : 8'd0;
        end else begin
          tick_count_next = tick_count + 8'd1;
        end
      end
    end

    result.scl_level   = scl;
    result.sda_release = rel;
    result.busy_res    = (phase_next != PH_IDLE);
    result.done_res    = done;
    result.read_byte   = received_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      stage         <= SG_CTRL;
      bit_index     <= 4'd0;
      shift_byte    <= 8'd0;
      tick_count    <= 8'd0;
      held_address  <= 16'd0;
      held_data     <= 8'd0;
      held_is_read  <= 1'b0;
      held_target   <= 1'b0;
      held_control  <= 8'd0;
      received_byte <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      stage         <= stage_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      tick_count    <= tick_count_next;
      held_address  <= held_address_next;
      held_data     <= held_data_next;
      held_is_read  <= held_is_read_next;
      held_target   <= held_target_next;
      held_control  <= held_control_next;
      received_byte <= received_byte_next;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && is_cmd |=> phase == PH_ST_LO)
    else $error("command load did not enter start sequence");

  a_done_from_stop: assert property (@(posedge clk) disable iff (rst)
    result.done_res |-> phase == PH_SP_REL && stage != SG_WSTOP)
    else $error("done outside final stop release");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    result.cmd_rejected |-> phase != PH_IDLE)
    else $error("command rejected while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= 4'd8)
    else $error("bit index past byte end");

endmodule

`default_nettype wire

// ===== design/i2c_eeprom_rtc_byte_master_top.sv =====
// Top level of the I2C EEPROM / clock chip byte master.
// Depends on iebm_pkg, iebm_cfg_regs, iebm_bus_engine.
`default_nettype none

// Channel  Handshake                     Payload      Beat
// cmd      cmd_valid / cmd_ready         iebm_pkg::cmd_t  one bus tick or command
// res      res_valid / res_ready         iebm_pkg::res_t  line levels and status
// apb      psel,penable,pwrite / pready  paddr,pwdata     register write, read
//
// A cmd beat lands in an input register; the bus engine advances on it once the
// output register is free or being drained, and its result lands in the output
// register: one beat per cycle while res_ready holds, set by the single engine step.
// Reset (rst, synchronous) empties both registers and returns the bus to idle
// with the configuration at its defaults.
// A stalled res side holds the result; the input register then keeps one
// more beat before cmd_ready drops.

module i2c_eeprom_rtc_byte_master_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  iebm_pkg::cmd_t                     cmd,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output iebm_pkg::res_t                     res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [iebm_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [iebm_pkg::ApbDataW-1:0] pwdata,
  output logic      [iebm_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import iebm_pkg::*;

  cfg_t cfg;
  cmd_t in_q;
  logic in_q_valid;
  logic advance;
  res_t step_res;

  // engine steps when an item sits in the input register and the output
  // register is free or being drained
  assign advance   = in_q_valid && (!res_valid || res_ready);
  assign cmd_ready = !in_q_valid || advance;

  iebm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iebm_bus_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (in_q),
    .result (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      in_q <= cmd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

endmodule

`default_nettype wire
